@@ sv/lsc_pkg.sv @@
`default_nettype none
package lsc_pkg;
	localparam int CW = 16;
	localparam int PW = 2 * CW + 2;
	localparam int QW = PW;
	localparam int MAX_MOVES = 4;
	localparam logic [3:0] CODE_TOP = 4'd8;
	localparam logic [3:0] CODE_BOTTOM = 4'd4;
	localparam logic [3:0] CODE_RIGHT = 4'd2;
	localparam logic [3:0] CODE_LEFT = 4'd1;
	localparam logic [1:0] REG_LEFT = 2'd0;
	localparam logic [1:0] REG_RIGHT = 2'd1;
	localparam logic [1:0] REG_BOTTOM = 2'd2;
	localparam logic [1:0] REG_TOP = 2'd3;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t l;
		coord_t r;
		coord_t b;
		coord_t t;
	} win_t;

	function automatic logic [3:0] outcode(coord_t x, coord_t y, win_t w);
		logic [3:0] c;
		c = '0;
		if (y > w.t) c = c | CODE_TOP;
		if (y < w.b) c = c | CODE_BOTTOM;
		if (x > w.r) c = c | CODE_RIGHT;
		if (x < w.l) c = c | CODE_LEFT;
		return c;
	endfunction
endpackage
`default_nettype wire

@@ sv/line_segment_clipper.sv @@
// Cohen-Sutherland line clipper, Q12.4 coordinates.
// s_axis: tdata holds start_x, start_y, end_x, end_y from bit 0 up.
// m_axis: tdata holds clipped_start_x .. clipped_end_y; tuser is visible.
// cfg: valid/ready write of index (0 left, 1 right, 2 bottom, 3 top) and data;
// other indexes are ignored. cfg_ready is always high.
// A chain of four clip cells makes at most one endpoint move each; a cell
// with nothing to move passes the segment through its IDLE and FIN states,
// and a move goes on through MUL and DIV, where the 34-step bit-serial
// divider inside the cell runs. One segment is in flight at a time, and
// the last cell's done sets m_axis_tvalid. The result waits in an output
// register while m_axis_tready is low, and s_axis_tready stays low until it
// is taken; the next segment can be accepted in the cycle after that.
// Reset loads the default window (-3200, 3200, -2400, 2400) and empties
// the chain.
`default_nettype none
module line_segment_clipper import lsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	input  wire logic [4*CW-1:0] s_axis_tdata, // start_x, start_y, end_x, end_y
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [4*CW-1:0] m_axis_tdata, // clipped_start_x/y, clipped_end_x/y
	output logic [0:0] m_axis_tuser, // visible
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [CW-1:0] cfg_data
);
	win_t win_q;
	logic busy_q;
	logic [MAX_MOVES:0] st;
	coord_t cx1 [MAX_MOVES+1];
	coord_t cy1 [MAX_MOVES+1];
	coord_t cx2 [MAX_MOVES+1];
	coord_t cy2 [MAX_MOVES+1];
	logic acc;
	logic vis;

	assign cfg_ready = 1'b1;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy_q && !m_axis_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.l <= -CW'(3200);
			win_q.r <= CW'(3200);
			win_q.b <= -CW'(2400);
			win_q.t <= CW'(2400);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LEFT: win_q.l <= cfg_data;
				REG_RIGHT: win_q.r <= cfg_data;
				REG_BOTTOM: win_q.b <= cfg_data;
				REG_TOP: win_q.t <= cfg_data;
				default: ;
			endcase
		end
	end

	assign st[0] = acc;
	assign cx1[0] = s_axis_tdata[CW-1:0];
	assign cy1[0] = s_axis_tdata[2*CW-1:CW];
	assign cx2[0] = s_axis_tdata[3*CW-1:2*CW];
	assign cy2[0] = s_axis_tdata[4*CW-1:3*CW];

	for (genvar i = 0; i < MAX_MOVES; i++) begin : g_cell
		lsc_clip_cell u_cell (
			.clk(clk), .arst_n(arst_n), .start(st[i]), .win(win_q),
			.x1_in(cx1[i]), .y1_in(cy1[i]), .x2_in(cx2[i]), .y2_in(cy2[i]),
			.done(st[i+1]),
			.x1_out(cx1[i+1]), .y1_out(cy1[i+1]),
			.x2_out(cx2[i+1]), .y2_out(cy2[i+1])
		);
	end

	assign vis = (outcode(cx1[MAX_MOVES], cy1[MAX_MOVES], win_q)
		| outcode(cx2[MAX_MOVES], cy2[MAX_MOVES], win_q)) == 4'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (acc) busy_q <= 1'b1;
			if (st[MAX_MOVES]) begin
				busy_q <= 1'b0;
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st[MAX_MOVES]) begin
			m_axis_tuser <= vis;
			m_axis_tdata <= vis ? {cy2[MAX_MOVES], cx2[MAX_MOVES], cy1[MAX_MOVES],
				cx1[MAX_MOVES]} : '0;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_axis_tready) else $error("accept while busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st[MAX_MOVES] |-> busy_q) else $error("result without segment");
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata == '0)
		else $error("rejected segment not zero");
endmodule
`default_nettype wire

@@ sv/lsc_div_cell.sv @@
`default_nettype none
module lsc_div_cell import lsc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [PW-1:0] num,
	input  wire logic [CW:0]   den,
	output logic               done,
	output logic [QW-1:0]      quo
);
	logic [CW:0]   den_q;
	logic [$clog2(PW+1)-1:0] cnt_q;
	logic          busy_q;
	logic [PW+CW:0] acc_q;
	logic [CW+1:0] sub;

	assign sub = {1'b0, acc_q[PW+CW-1:PW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ($clog2(PW+1))'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(PW+1))'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {{(CW+1){1'b0}}, num};
			den_q <= den;
		end else if (busy_q) begin
			if (!sub[CW+1])
				acc_q <= {sub[CW:0], acc_q[PW-2:0], 1'b1};
			else
				acc_q <= {acc_q[PW+CW-1:0], 1'b0};
		end
	end

	assign quo = acc_q[QW-1:0];
endmodule
`default_nettype wire

@@ sv/lsc_clip_cell.sv @@
`default_nettype none
module lsc_clip_cell import lsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire win_t win,
	input  wire coord_t x1_in,
	input  wire coord_t y1_in,
	input  wire coord_t x2_in,
	input  wire coord_t y2_in,
	output logic done,
	output coord_t x1_out,
	output coord_t y1_out,
	output coord_t x2_out,
	output coord_t y2_out
);
	typedef enum logic [1:0] {IDLE, MUL, DIV, FIN} st_t;
	st_t st_q;
	coord_t x1_q, y1_q, x2_q, y2_q;
	logic [3:0] c1, c2, o;
	logic signed [CW:0] d_s, n_s, den_s;
	logic signed [CW:0] den_q;
	logic [PW-1:0] prod_q;
	logic neg_q, side_q, vert_q;
	coord_t edge_q, base_q;
	logic div_done;
	logic [QW-1:0] quo;
	logic signed [QW:0] res;

	assign c1 = outcode(x1_q, y1_q, win);
	assign c2 = outcode(x2_q, y2_q, win);
	assign o = (c1 != 4'd0) ? c1 : c2;

	always_comb begin
		if ((o & (CODE_TOP | CODE_BOTTOM)) != 4'd0) begin
			d_s = (CW+1)'(x2_q) - (CW+1)'(x1_q);
			n_s = ((o & CODE_TOP) != 4'd0 ? (CW+1)'(win.t) : (CW+1)'(win.b))
				- (CW+1)'(y1_q);
			den_s = (CW+1)'(y2_q) - (CW+1)'(y1_q);
		end else begin
			d_s = (CW+1)'(y2_q) - (CW+1)'(y1_q);
			n_s = ((o & CODE_RIGHT) != 4'd0 ? (CW+1)'(win.r) : (CW+1)'(win.l))
				- (CW+1)'(x1_q);
			den_s = (CW+1)'(x2_q) - (CW+1)'(x1_q);
		end
	end

	lsc_div_cell u_div (
		.clk(clk), .arst_n(arst_n), .start(st_q == MUL),
		.num(prod_q), .den(den_q[CW] ? -den_q : den_q),
		.done(div_done), .quo(quo)
	);

	assign res = neg_q ? (QW+1)'(base_q) - (QW+1)'(quo) : (QW+1)'(base_q) + (QW+1)'(quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				IDLE: if (start) st_q <= FIN;
				FIN: begin
					if ((c1 | c2) == 4'd0 || (c1 & c2) != 4'd0) begin
						done <= 1'b1;
						st_q <= IDLE;
					end else st_q <= MUL;
				end
				MUL: st_q <= DIV;
				DIV: if (div_done) st_q <= IDLE;
				default: st_q <= IDLE;
			endcase
			if (st_q == DIV && div_done) done <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == IDLE && start) begin
			x1_q <= x1_in; y1_q <= y1_in; x2_q <= x2_in; y2_q <= y2_in;
		end
		if (st_q == FIN) begin
			prod_q <= PW'((d_s[CW] ? -d_s : d_s)) * PW'((n_s[CW] ? -n_s : n_s));
			den_q <= den_s;
			neg_q <= (d_s != 0 && n_s != 0) && ((d_s[CW] ^ n_s[CW]) ^ den_s[CW]);
			side_q <= (c1 != 4'd0);
			vert_q <= (o & (CODE_TOP | CODE_BOTTOM)) != 4'd0;
			if ((o & CODE_TOP) != 4'd0) edge_q <= win.t;
			else if ((o & CODE_BOTTOM) != 4'd0) edge_q <= win.b;
			else if ((o & CODE_RIGHT) != 4'd0) edge_q <= win.r;
			else edge_q <= win.l;
			base_q <= ((o & (CODE_TOP | CODE_BOTTOM)) != 4'd0) ? x1_q : y1_q;
		end
		if (st_q == DIV && div_done) begin
			if (side_q) begin
				if (vert_q) begin x1_q <= CW'(res); y1_q <= edge_q; end
				else begin x1_q <= edge_q; y1_q <= CW'(res); end
			end else begin
				if (vert_q) begin x2_q <= CW'(res); y2_q <= edge_q; end
				else begin x2_q <= edge_q; y2_q <= CW'(res); end
			end
		end
	end

	assign x1_out = x1_q;
	assign y1_out = y1_q;
	assign x2_out = x2_q;
	assign y2_out = y2_q;
endmodule
`default_nettype wire

@@ tb/line_segment_clipper_checker.sv @@
`default_nettype none
module line_segment_clipper_checker import lsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	input  wire logic s_axis_tready,
	input  wire logic [4*CW-1:0] s_axis_tdata,
	input  wire logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	input  wire logic [4*CW-1:0] m_axis_tdata,
	input  wire logic [0:0] m_axis_tuser,
	input  wire logic cfg_valid,
	input  wire logic cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [CW-1:0] cfg_data,
	output int mismatches,
	output int pending,
	output int visible_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic visible;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} clip_result_t;

	coord_t win_left, win_right, win_bottom, win_top;
	clip_result_t clip_queue[$];

	function automatic logic [3:0] region_code(longint x, longint y);
		logic [3:0] c;
		c = '0;
		if (y > longint'(win_top)) c |= CODE_TOP;
		if (y < longint'(win_bottom)) c |= CODE_BOTTOM;
		if (x > longint'(win_right)) c |= CODE_RIGHT;
		if (x < longint'(win_left)) c |= CODE_LEFT;
		return c;
	endfunction

	function automatic clip_result_t clip_segment(logic [4*CW-1:0] seg);
		clip_result_t res;
		longint x1, y1, x2, y2, x, y;
		logic [3:0] c1, c2, o;
		x1 = longint'(coord_t'(seg[CW-1:0]));
		y1 = longint'(coord_t'(seg[2*CW-1:CW]));
		x2 = longint'(coord_t'(seg[3*CW-1:2*CW]));
		y2 = longint'(coord_t'(seg[4*CW-1:3*CW]));
		c1 = region_code(x1, y1);
		c2 = region_code(x2, y2);
		for (int m = 0; m < MAX_MOVES; m++) begin
			if ((c1 | c2) == 0 || (c1 & c2) != 0)
				break;
			o = (c1 != 0) ? c1 : c2;
			if (o & CODE_TOP) begin
				y = win_top;
				x = x1 + (x2 - x1) * (y - y1) / (y2 - y1);
			end else if (o & CODE_BOTTOM) begin
				y = win_bottom;
				x = x1 + (x2 - x1) * (y - y1) / (y2 - y1);
			end else if (o & CODE_RIGHT) begin
				x = win_right;
				y = y1 + (y2 - y1) * (x - x1) / (x2 - x1);
			end else begin
				x = win_left;
				y = y1 + (y2 - y1) * (x - x1) / (x2 - x1);
			end
			if (c1 != 0) begin
				x1 = x; y1 = y; c1 = region_code(x1, y1);
			end else begin
				x2 = x; y2 = y; c2 = region_code(x2, y2);
			end
		end
		res.visible = (c1 | c2) == 0;
		res.sx = res.visible ? coord_t'(x1) : '0;
		res.sy = res.visible ? coord_t'(y1) : '0;
		res.ex = res.visible ? coord_t'(x2) : '0;
		res.ey = res.visible ? coord_t'(y2) : '0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		clip_result_t want;
		clip_result_t got;
		if (!arst_n) begin
			win_left <= -16'sd3200;
			win_right <= 16'sd3200;
			win_bottom <= -16'sd2400;
			win_top <= 16'sd2400;
			clip_queue.delete();
			mismatches <= 0;
			visible_seen <= 0;
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				clip_queue.push_back(clip_segment(s_axis_tdata));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LEFT: win_left <= cfg_data;
					REG_RIGHT: win_right <= cfg_data;
					REG_BOTTOM: win_bottom <= cfg_data;
					REG_TOP: win_top <= cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.visible = m_axis_tuser[0];
				got.sx = m_axis_tdata[CW-1:0];
				got.sy = m_axis_tdata[2*CW-1:CW];
				got.ex = m_axis_tdata[3*CW-1:2*CW];
				got.ey = m_axis_tdata[4*CW-1:3*CW];
				if (got.visible)
					visible_seen <= visible_seen + 1;
				if (clip_queue.size() == 0) begin
					if (mismatches < 10)
						$display("ERROR: unexpected result transaction vis=%0d (%0d,%0d)-(%0d,%0d)",
							got.visible, got.sx, got.sy, got.ex, got.ey);
					mismatches <= mismatches + 1;
				end else begin
					want = clip_queue.pop_front();
					if (got.visible !== want.visible || got.sx !== want.sx ||
							got.sy !== want.sy || got.ex !== want.ex || got.ey !== want.ey) begin
						if (mismatches < 10)
							$display("ERROR: expected vis=%0d (%0d,%0d)-(%0d,%0d) got vis=%0d (%0d,%0d)-(%0d,%0d)",
								want.visible, want.sx, want.sy, want.ex, want.ey,
								got.visible, got.sx, got.sy, got.ex, got.ey);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= clip_queue.size();
		end
	end
endmodule
`default_nettype wire

@@ tb/tb_line_segment_clipper.sv @@
`default_nettype none
module tb_line_segment_clipper;
	import lsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [4*CW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [4*CW-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;
	int mismatches, pending, visible_seen;
	int cycles = 0;
	int segments_sent = 0;
	int windows_used = 0;
	int sink_hold = 0;
	bit calm = 1'b0;
	coord_t wl = -16'sd3200, wr = 16'sd3200, wb = -16'sd2400, wt = 16'sd2400;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	line_segment_clipper uut (.*);

	line_segment_clipper_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("line_segment_clipper verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			sink_hold <= $urandom_range(0, 6);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ey, ex, sy, sx};
		do @(posedge clk); while (!s_axis_tready);
		segments_sent++;
	endtask

	task automatic write_window(coord_t l, coord_t r, coord_t b, coord_t t);
		logic [1:0] idx [4];
		coord_t val [4];
		idx = '{REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP};
		val = '{l, r, b, t};
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		wl = l; wr = r; wb = b; wt = t;
		windows_used++;
	endtask

	function automatic coord_t pick_coord(coord_t lo, coord_t hi);
		int span;
		case ($urandom_range(0, 9))
			0, 1: return coord_t'($urandom);
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			3: return $urandom_range(0, 1) ? lo : hi;
			default: begin
				span = (int'(hi) - int'(lo)) / 2 + 500;
				return coord_t'(int'(lo) - span +
					int'($urandom_range(0, 2 * span + int'(hi) - int'(lo))));
			end
		endcase
	endfunction

	task automatic random_segments(int n);
		for (int i = 0; i < n; i++)
			send_segment(pick_coord(wl, wr), pick_coord(wb, wt),
				pick_coord(wl, wr), pick_coord(wb, wt));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_segment(0, 0, 100, 100);
		send_segment(-3200, 2400, 3200, -2400);
		send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_segment(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		send_segment(16'sh8000, 0, 16'sh7fff, 1);
		send_segment(-5000, 0, -4000, 100);
		send_segment(5000, 0, 4000, -100);
		send_segment(0, 3000, 100, 9000);
		send_segment(0, -3000, -100, -9000);
		send_segment(0, 0, 0, 5000);
		send_segment(0, 0, 0, -5000);
		send_segment(0, 0, 5000, 10);
		send_segment(0, 0, -5000, -10);
		send_segment(-5000, -3000, 5000, 3000);
		send_segment(-4000, 2000, -2000, 4000);
		send_segment(4000, -2000, 2000, -4000);
		send_segment(-3201, -2401, 3201, 2401);
		send_segment(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		write_window(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		random_segments(130);
		write_window(3200, -3200, 2400, -2400);
		random_segments(90);
		write_window(0, 0, 0, 0);
		random_segments(90);
		write_window(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
		random_segments(60);
		for (int p = 0; p < 3; p++) begin
			automatic int a = $urandom_range(0, 40000) - 20000;
			automatic int c = $urandom_range(0, 40000) - 20000;
			write_window(coord_t'(a), coord_t'(a + $urandom_range(1, 12000)),
				coord_t'(c), coord_t'(c + $urandom_range(1, 12000)));
			random_segments(110);
		end
		write_window(-3200, 3200, -2400, 2400);
		random_segments(50);
		calm = 1'b1;
		random_segments(50);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Clipped %0d segments (%0d visible) across %0d window settings,",
			segments_sent, visible_seen, windows_used);
		$display("including full-range, inverted and degenerate windows.");
		if (mismatches == 0) begin
			$display("line_segment_clipper verification clean");
		end else begin
			$display("line_segment_clipper verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ line_segment_clipper.f @@
sv/lsc_pkg.sv
sv/lsc_div_cell.sv
sv/lsc_clip_cell.sv
sv/line_segment_clipper.sv
tb/line_segment_clipper_checker.sv
tb/tb_line_segment_clipper.sv
